@@ hw/rtl/pws_pkg.sv @@
// Shared types and constants for the paced window sender.
package pws_pkg;

  localparam logic [1:0] OP_ACK     = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [2:0] REG_PAYLOAD  = 3'd0;
  localparam logic [2:0] REG_WINDOW   = 3'd1;
  localparam logic [2:0] REG_RATE     = 3'd2;
  localparam logic [2:0] REG_SEQUENCE = 3'd3;
  localparam logic [2:0] REG_IP_ID    = 3'd4;
  localparam logic [2:0] REG_TIMEOUT  = 3'd5;

  localparam logic [63:0] NEVER    = '1;
  localparam logic [63:0] NS_PER_S = 64'd1000000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_CHECK,
    ST_RATE_LO,
    ST_RATE_HI,
    ST_RATE_DONE,
    ST_SEND_CHECK,
    ST_COUNT_DIV,
    ST_BYTES_MUL,
    ST_TIME_MUL,
    ST_TIME_DIV,
    ST_COMMIT,
    ST_OUTPUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic do_ack;
    logic do_restart;
    logic load_in;
    logic timeout_apply;
    logic rate_mul;
    logic rate_mul_lo;
    logic rate_mul_hi;
    logic rate_done;
    logic count_div_start;
    logic count_done;
    logic bytes_mul;
    logic time_mul;
    logic time_div_start;
    logic commit;
    logic clear_result;
    logic result_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic timeout_hit;
    logic send_ok;
    logic count_nonzero;
    logic div_busy;
  } status_t;

endpackage

@@ hw/rtl/pws_divider.sv @@
// Restoring serial divider, one quotient bit per cycle.
module pws_divider #(
  parameter int Width = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [Width-1:0] dividend,
  input  logic [Width-1:0] divisor,
  output logic             busy,
  output logic [Width-1:0] quotient
);

  localparam int CntW = $clog2(Width + 1);

  logic [Width-1:0] rem;
  logic [Width-1:0] dvs;
  logic [CntW-1:0]  cnt;
  logic [Width:0]   trial;

  assign trial = {rem, quotient[Width-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= CntW'(Width);
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (trial[Width]) begin
        rem      <= {rem[Width-2:0], quotient[Width-1]};
        quotient <= {quotient[Width-2:0], 1'b0};
      end else begin
        rem      <= trial[Width-1:0];
        quotient <= {quotient[Width-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/pws_datapath.sv @@
// Sender state, config registers, arithmetic and result register.
module pws_datapath #(
  parameter int MaxBurst = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_index,
  input  logic [33:0]     cfg_data,
  input  logic [63:0]     in_now_ns,
  input  logic [31:0]     in_ack_number,
  input  pws_pkg::cmd_t   cmd,
  output pws_pkg::status_t status,
  output logic [8:0]      segment_count,
  output logic [31:0]     first_sequence,
  output logic [15:0]     first_ip_id,
  output logic            timed_out,
  output logic [33:0]     rate_now
);

  localparam int CountW = $clog2(MaxBurst + 1);

  // ceil(2^42 / 125): floor(z / 125) == (z * RecipM) >> 42 for z below 2^35.
  localparam logic [35:0] RecipM = 36'd35184372089;

  logic [10:0] payload_bytes;
  logic [16:0] window_bytes;
  logic [33:0] start_rate;
  logic [31:0] start_sequence;
  logic [15:0] start_ip_id;
  logic [31:0] resend_timeout_ns;

  logic [31:0] oldest_unacked, next_sequence;
  logic [15:0] next_ip_id;
  logic [33:0] pacing_rate;
  logic [63:0] resend_deadline, next_send_time;

  logic [63:0] now;
  logic [31:0] ack;
  logic [63:0] prod;
  logic [CountW-1:0] count;
  logic [27:0] bytes;

  logic        div_start;
  logic [63:0] div_a, div_b, div_q;
  logic        div_busy;

  logic [31:0] diff, inflight;
  logic [64:0] dl_sum;
  logic [63:0] dl_sat;

  // Rate cut: (r*992+999)/1000 == r + 1 - floor((r + 125) / 125).
  logic [34:0] rate_z;
  logic [53:0] rate_lo, rate_lo_prod;
  logic [52:0] rate_hi_prod;
  logic [71:0] rate_sum;
  logic [29:0] rate_q;
  logic [33:0] rate_cut;

  assign rate_lo_prod = {36'd0, rate_z[17:0]} * {18'd0, RecipM};
  assign rate_hi_prod = {36'd0, rate_z[34:18]} * {17'd0, RecipM};
  assign rate_sum     = {18'd0, rate_lo} + {1'b0, rate_hi_prod, 18'd0};
  assign rate_cut     = pacing_rate + 34'd1 - {4'd0, rate_q};

  assign diff     = ack - oldest_unacked;
  assign inflight = next_sequence - oldest_unacked;
  assign dl_sum   = {1'b0, now} + {33'd0, resend_timeout_ns};
  assign dl_sat   = dl_sum[64] ? pws_pkg::NEVER : dl_sum[63:0];

  assign status.timeout_hit   = (resend_deadline != pws_pkg::NEVER) && (now >= resend_deadline);
  assign status.send_ok       = (now > next_send_time) && (inflight < {15'd0, window_bytes})
                                && (payload_bytes != 11'd0);
  assign status.count_nonzero = (count != '0);
  assign status.div_busy      = div_busy;

  assign div_start = cmd.count_div_start | cmd.time_div_start;

  always_comb begin
    div_a = prod;
    div_b = {30'd0, pacing_rate};
    if (cmd.count_div_start) begin
      div_a = 64'({15'd0, window_bytes} - inflight);
      div_b = {53'd0, payload_bytes};
    end
  end

  pws_divider #(.Width(64)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .quotient (div_q)
  );

  logic [64:0] ns_sum;
  assign ns_sum = {1'b0, now} + {1'b0, div_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes     <= 11'd1024;
      window_bytes      <= 17'd65535;
      start_rate        <= 34'd125000000;
      start_sequence    <= 32'd12345678;
      start_ip_id       <= 16'd0;
      resend_timeout_ns <= 32'd100000000;
      oldest_unacked    <= '0;
      next_sequence     <= '0;
      next_ip_id        <= '0;
      pacing_rate       <= 34'd1;
      resend_deadline   <= pws_pkg::NEVER;
      next_send_time    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pws_pkg::REG_PAYLOAD:  payload_bytes     <= cfg_data[10:0];
          pws_pkg::REG_WINDOW:   window_bytes      <= cfg_data[16:0];
          pws_pkg::REG_RATE:     start_rate        <= cfg_data;
          pws_pkg::REG_SEQUENCE: start_sequence    <= cfg_data[31:0];
          pws_pkg::REG_IP_ID:    start_ip_id       <= cfg_data[15:0];
          pws_pkg::REG_TIMEOUT:  resend_timeout_ns <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (cmd.do_ack && diff != 32'd0 && !diff[31]) begin
        oldest_unacked  <= ack;
        resend_deadline <= (ack == next_sequence) ? pws_pkg::NEVER : dl_sat;
      end
      if (cmd.do_restart) begin
        oldest_unacked  <= start_sequence;
        next_sequence   <= start_sequence;
        next_ip_id      <= start_ip_id;
        pacing_rate     <= (start_rate == 34'd0) ? 34'd1 : start_rate;
        resend_deadline <= pws_pkg::NEVER;
        next_send_time  <= '0;
      end
      if (cmd.timeout_apply) begin
        next_sequence   <= oldest_unacked;
        resend_deadline <= pws_pkg::NEVER;
      end
      if (cmd.rate_done) begin
        pacing_rate <= (rate_cut == 34'd0) ? 34'd1 : rate_cut;
      end
      if (cmd.commit) begin
        next_sequence   <= next_sequence + {4'd0, bytes};
        next_ip_id      <= next_ip_id + 16'(count);
        next_send_time  <= ns_sum[64] ? pws_pkg::NEVER : ns_sum[63:0];
        resend_deadline <= dl_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now <= in_now_ns;
      ack <= in_ack_number;
    end
    if (cmd.rate_mul) begin
      rate_z <= {1'b0, pacing_rate} + 35'd125;
    end
    if (cmd.rate_mul_lo) begin
      rate_lo <= rate_lo_prod;
    end
    if (cmd.rate_mul_hi) begin
      rate_q <= rate_sum[71:42];
    end
    if (cmd.clear_result) begin
      count          <= '0;
      timed_out      <= cmd.timeout_apply;
      segment_count  <= '0;
      first_sequence <= '0;
      first_ip_id    <= '0;
    end
    if (cmd.count_done) begin
      count <= (div_q > 64'(MaxBurst)) ? CountW'(MaxBurst) : div_q[CountW-1:0];
    end
    if (cmd.bytes_mul) begin
      bytes <= 28'(count) * {17'd0, payload_bytes};
    end
    if (cmd.time_mul) begin
      prod <= pws_pkg::NS_PER_S * {36'd0, bytes};
    end
    if (cmd.commit) begin
      segment_count  <= 9'(count);
      first_sequence <= next_sequence;
      first_ip_id    <= next_ip_id;
    end
    if (cmd.result_load) begin
      rate_now <= pacing_rate;
    end
  end

endmodule

@@ hw/rtl/pws_control.sv @@
// Sequencer for ack, restart and tick items.
module pws_control (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [1:0]       s_op,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  pws_pkg::status_t status,
  output pws_pkg::cmd_t    cmd
);

  pws_pkg::state_t state, state_next;
  logic [1:0] op;
  logic out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pws_pkg::ST_IDLE;
      out_full <= 1'b0;
      op       <= '0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
      if (s_tvalid && s_tready) op <= s_op;
    end
  end

  assign m_tvalid = out_full;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_tready      = 1'b0;
    out_full_next = out_full && !m_tready;
    case (state)
      pws_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = pws_pkg::ST_TICK_CHECK;
        end
      end
      pws_pkg::ST_TICK_CHECK: begin
        if (op == pws_pkg::OP_ACK) begin
          cmd.do_ack = 1'b1;
          state_next = pws_pkg::ST_IDLE;
        end else if (op == pws_pkg::OP_RESTART) begin
          cmd.do_restart = 1'b1;
          state_next     = pws_pkg::ST_IDLE;
        end else if (op != pws_pkg::OP_TICK) begin
          state_next = pws_pkg::ST_IDLE;
        end else if (!out_full_next) begin
          cmd.clear_result = 1'b1;
          if (status.timeout_hit) begin
            cmd.timeout_apply = 1'b1;
            cmd.rate_mul      = 1'b1;
            state_next        = pws_pkg::ST_RATE_LO;
          end else begin
            state_next = pws_pkg::ST_SEND_CHECK;
          end
        end
      end
      pws_pkg::ST_RATE_LO: begin
        cmd.rate_mul_lo = 1'b1;
        state_next      = pws_pkg::ST_RATE_HI;
      end
      pws_pkg::ST_RATE_HI: begin
        cmd.rate_mul_hi = 1'b1;
        state_next      = pws_pkg::ST_RATE_DONE;
      end
      pws_pkg::ST_RATE_DONE: begin
        cmd.rate_done = 1'b1;
        state_next    = pws_pkg::ST_SEND_CHECK;
      end
      pws_pkg::ST_SEND_CHECK: begin
        if (status.send_ok) begin
          cmd.count_div_start = 1'b1;
          state_next          = pws_pkg::ST_COUNT_DIV;
        end else begin
          state_next = pws_pkg::ST_OUTPUT;
        end
      end
      pws_pkg::ST_COUNT_DIV: begin
        if (!status.div_busy) begin
          cmd.count_done = 1'b1;
          state_next     = pws_pkg::ST_BYTES_MUL;
        end
      end
      pws_pkg::ST_BYTES_MUL: begin
        if (status.count_nonzero) begin
          cmd.bytes_mul = 1'b1;
          state_next    = pws_pkg::ST_TIME_MUL;
        end else begin
          state_next = pws_pkg::ST_OUTPUT;
        end
      end
      pws_pkg::ST_TIME_MUL: begin
        cmd.time_mul = 1'b1;
        state_next   = pws_pkg::ST_TIME_DIV;
      end
      pws_pkg::ST_TIME_DIV: begin
        cmd.time_div_start = 1'b1;
        state_next         = pws_pkg::ST_COMMIT;
      end
      pws_pkg::ST_COMMIT: begin
        if (!status.div_busy) begin
          cmd.commit = 1'b1;
          state_next = pws_pkg::ST_OUTPUT;
        end
      end
      pws_pkg::ST_OUTPUT: begin
        cmd.result_load = 1'b1;
        out_full_next   = 1'b1;
        state_next      = pws_pkg::ST_IDLE;
      end
      default: state_next = pws_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/paced_window_sender_unit.sv @@
// Top level of the paced window sender: ack, tick and restart items in, burst words out.
// Ack and restart items pass through the load and check states only; a tick that sends uses the
// shared 64-step serial divider (burst count and send-time division run on it), and the rate cut
// is a two-step reciprocal multiply.
// Throughput: one item at a time; the result register lets the next item start while a
// finished word waits, a tick only stalls if the previous result is still untaken.
// Reset: synchronous rst loads the default registers and clears the sender state.
module paced_window_sender_unit #(
  parameter int MaxBurst = 256
) (
  input  logic         clk,
  input  logic         rst,
  // Input words.
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // operation[1:0], now_ns[65:2], ack_number[97:66], zero pad
  // Result words.
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // segment_count[8:0], first_sequence[40:9],
                                  // first_ip_id[56:41], timed_out[57], rate_now[91:58], pad
  // Configuration writes.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [33:0]  cfg_data
);

  pws_pkg::cmd_t    cmd;
  pws_pkg::status_t status;

  logic [8:0]  segment_count;
  logic [31:0] first_sequence;
  logic [15:0] first_ip_id;
  logic        timed_out;
  logic [33:0] rate_now;

  // Config writes must come only while idle; the block does not enforce this and always accepts.
  assign cfg_ready = 1'b1;

  pws_control u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_op     (s_tdata[1:0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pws_datapath #(.MaxBurst(MaxBurst)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_now_ns      (s_tdata[65:2]),
    .in_ack_number  (s_tdata[97:66]),
    .cmd            (cmd),
    .status         (status),
    .segment_count  (segment_count),
    .first_sequence (first_sequence),
    .first_ip_id    (first_ip_id),
    .timed_out      (timed_out),
    .rate_now       (rate_now)
  );

  // Result words hold until taken: fields only change in a tick after out_full clears.
  assign m_tdata = {4'd0, rate_now, timed_out, first_ip_id, first_sequence, segment_count};

endmodule

@@ dv/paced_window_sender_unit_tb.sv @@
// Self-checking testbench for the paced window sender: directed table plus random items.
module paced_window_sender_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;   // idle wait once all expected words are taken
  localparam int PHASE_ITEMS    = 150;
  localparam int N_DIRECTED     = 12;
  localparam int BURST_CAP      = 256;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [2:0] REG_UNUSED6 = 3'd6;
  localparam logic [2:0] REG_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [8:0]  count;
    logic [31:0] seq;
    logic [15:0] ip_id;
    logic        timed;
    logic [33:0] rate;
  } burst_t;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] now;
    logic [31:0] ack;
    bit          typed;
    burst_t      want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [33:0]  cfg_data = '0;

  paced_window_sender_unit uut (.*);

  always #2 clk = ~clk;

  // Predictor copy of registers and sender state.
  logic [10:0] p_payload;
  logic [16:0] p_window;
  logic [33:0] p_start_rate;
  logic [31:0] p_start_seq;
  logic [15:0] p_start_id;
  logic [31:0] p_timeout;
  logic [31:0] p_oldest, p_next_seq;
  logic [15:0] p_next_id;
  logic [63:0] p_rate, p_deadline, p_send_time;

  burst_t bursts_due[$];
  int errors = 0;
  int n_ticks = 0, n_timeouts = 0, n_sends = 0, n_words = 0;
  int idle_mode = 0;       // 0 none, 1 sender idles, 2 receiver stalls, 3 both
  int hold_req = 0;        // long receiver hold-off request, cycles
  int quiet = 0;

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? pws_pkg::NEVER : s[63:0];
  endfunction

  task automatic model_reset();
    p_payload = 11'd1024; p_window = 17'd65535; p_start_rate = 34'd125000000;
    p_start_seq = 32'd12345678; p_start_id = '0; p_timeout = 32'd100000000;
    p_oldest = '0; p_next_seq = '0; p_next_id = '0; p_rate = 64'd1;
    p_deadline = pws_pkg::NEVER; p_send_time = '0;
  endtask

  task automatic model_config(logic [2:0] idx, logic [33:0] val);
    case (idx)
      pws_pkg::REG_PAYLOAD:  p_payload    = val[10:0];
      pws_pkg::REG_WINDOW:   p_window     = val[16:0];
      pws_pkg::REG_RATE:     p_start_rate = val;
      pws_pkg::REG_SEQUENCE: p_start_seq  = val[31:0];
      pws_pkg::REG_IP_ID:    p_start_id   = val[15:0];
      pws_pkg::REG_TIMEOUT:  p_timeout    = val[31:0];
      default: ;
    endcase
  endtask

  // Advances the sender state for one word; returns 1 and the burst on a tick.
  function automatic bit sender_step(logic [1:0] op, logic [63:0] now, logic [31:0] ack,
                                     output burst_t b);
    logic [31:0] diff, inflight;
    logic [63:0] cnt, bytes;
    b = '0;
    if (op == pws_pkg::OP_ACK) begin
      diff = ack - p_oldest;
      if (diff != 0 && !diff[31]) begin
        p_oldest = ack;
        p_deadline = (p_oldest == p_next_seq) ? pws_pkg::NEVER
                                              : sat_add(now, {32'd0, p_timeout});
      end
      return 0;
    end
    if (op == pws_pkg::OP_RESTART) begin
      p_oldest = p_start_seq; p_next_seq = p_start_seq; p_next_id = p_start_id;
      p_rate = (p_start_rate == 0) ? 64'd1 : {30'd0, p_start_rate};
      p_deadline = pws_pkg::NEVER; p_send_time = '0;
      return 0;
    end
    if (op != pws_pkg::OP_TICK) return 0;
    if (p_deadline != pws_pkg::NEVER && now >= p_deadline) begin
      b.timed = 1'b1;
      p_next_seq = p_oldest;
      p_rate = (p_rate * 992 + 999) / 1000;
      if (p_rate == 0) p_rate = 1;
      p_deadline = pws_pkg::NEVER;
    end
    inflight = p_next_seq - p_oldest;
    if (now > p_send_time && {32'd0, inflight} < {47'd0, p_window} && p_payload != 0) begin
      cnt = ({47'd0, p_window} - {32'd0, inflight}) / {53'd0, p_payload};
      if (cnt > BURST_CAP) cnt = BURST_CAP;
      if (cnt != 0) begin
        bytes = cnt * {53'd0, p_payload};
        b.count = cnt[8:0]; b.seq = p_next_seq; b.ip_id = p_next_id;
        p_next_seq = p_next_seq + bytes[31:0];
        p_next_id = p_next_id + cnt[15:0];
        p_send_time = sat_add(now, (pws_pkg::NS_PER_S * bytes) / p_rate);
        p_deadline = sat_add(now, {32'd0, p_timeout});
      end
    end
    b.rate = p_rate[33:0];
    return 1;
  endfunction

  // Receiver: random stalls per idle mode, long hold-off on request.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      m_tready <= 1'b0;
      hold_req <= hold_req - 1;
    end else if (idle_mode >= 2) begin
      m_tready <= ($urandom_range(99) >= ((idle_mode == 2) ? 68 : 6));
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker against the oldest expected burst.
  always @(posedge clk) begin
    burst_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.count = m_tdata[8:0];
      got.seq   = m_tdata[40:9];
      got.ip_id = m_tdata[56:41];
      got.timed = m_tdata[57];
      got.rate  = m_tdata[91:58];
      n_words++;
      if (bursts_due.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        want = bursts_due.pop_front();
        if (got.count !== want.count)
          $display("%0t: segment_count exp %0d got %0d", $time, want.count, got.count);
        if (got.seq !== want.seq)
          $display("%0t: first_sequence exp %h got %h", $time, want.seq, got.seq);
        if (got.ip_id !== want.ip_id)
          $display("%0t: first_ip_id exp %h got %h", $time, want.ip_id, got.ip_id);
        if (got.timed !== want.timed)
          $display("%0t: timed_out exp %0d got %0d", $time, want.timed, got.timed);
        if (got.rate !== want.rate)
          $display("%0t: rate_now exp %0d got %0d", $time, want.rate, got.rate);
        if (got !== want) errors++;
      end
    end
  end

  // Watchdog: cycles without any accepted word.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("paced_window_sender_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [33:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_config(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drives one word; the typed burst, when given, overrides the predictor's.
  task automatic send_word(logic [1:0] op, logic [63:0] now, logic [31:0] ack,
                           bit typed = 0, burst_t want = '0);
    burst_t b;
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, ack, now, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (sender_step(op, now, ack, b)) begin
      n_ticks++;
      if (b.timed) n_timeouts++;
      if (b.count != 0) n_sends++;
      bursts_due.push_back(typed ? want : b);
    end
    if ((idle_mode == 1 && $urandom_range(99) < 68) ||
        (idle_mode == 3 && $urandom_range(99) < 6)) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (bursts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  logic [63:0] cur_now;

  // Random word: mostly ticks and acks near the send edge, some noise.
  task automatic random_word();
    int pick;
    logic [31:0] ack;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0:       cur_now = {$urandom, $urandom};
      1, 2:    cur_now = sat_add(cur_now, {32'd0, $urandom});
      3, 4, 5: cur_now = sat_add(cur_now, 64'($urandom_range(2000000)));
      default: cur_now = sat_add(cur_now, 64'($urandom_range(1000)));
    endcase
    if (pick < 35) begin
      case ($urandom_range(3))
        0:       ack = $urandom;
        1:       ack = p_next_seq + $urandom_range(3000);
        default: ack = p_oldest + $urandom_range(p_next_seq - p_oldest);
      endcase
      send_word(pws_pkg::OP_ACK, cur_now, ack);
    end else if (pick < 90) begin
      send_word(pws_pkg::OP_TICK, cur_now, $urandom);
    end else if (pick < 96) begin
      send_word(pws_pkg::OP_RESTART, cur_now, $urandom);
    end else begin
      send_word(OP_UNUSED, cur_now, $urandom);
    end
  endtask

  task automatic write_all(logic [33:0] pl, logic [33:0] win, logic [33:0] rate,
                           logic [33:0] seq, logic [33:0] id, logic [33:0] tmo);
    write_reg(pws_pkg::REG_PAYLOAD, pl);
    write_reg(pws_pkg::REG_WINDOW, win);
    write_reg(pws_pkg::REG_RATE, rate);
    write_reg(pws_pkg::REG_SEQUENCE, seq);
    write_reg(pws_pkg::REG_IP_ID, id);
    write_reg(pws_pkg::REG_TIMEOUT, tmo);
  endtask

  dir_row_t dir_rows[N_DIRECTED];

  initial begin
    model_reset();
    // Directed table at reset-default registers.
    dir_rows[0]  = '{pws_pkg::OP_TICK, 64'd0, 32'd0, 1,
                     '{9'd0, 32'd0, 16'd0, 1'b0, 34'd1}};
    dir_rows[1]  = '{pws_pkg::OP_RESTART, 64'd0, 32'd0, 0, '0};
    dir_rows[2]  = '{pws_pkg::OP_TICK, 64'd1000, 32'd0, 1,
                     '{9'd63, 32'd12345678, 16'd0, 1'b0, 34'd125000000}};
    dir_rows[3]  = '{pws_pkg::OP_TICK, 64'd1001, 32'hFFFFFFFF, 0, '0};  // pacing not passed
    dir_rows[4]  = '{pws_pkg::OP_ACK, 64'd2000, 32'd12345678 + 32'd10240, 0, '0};
    dir_rows[5]  = '{pws_pkg::OP_ACK, 64'd2100, 32'd12345678, 0, '0};   // stale ack
    dir_rows[6]  = '{pws_pkg::OP_TICK, 64'd900000, 32'd0, 0, '0};
    dir_rows[7]  = '{pws_pkg::OP_ACK, 64'd901000, 32'd12345678 + 32'd200000, 0, '0};
    dir_rows[8]  = '{pws_pkg::OP_TICK, 64'd2000000, 32'd0, 0, '0};      // negative in-flight
    dir_rows[9]  = '{pws_pkg::OP_TICK, 64'd200000000, 32'd0, 0, '0};    // timeout, rate cut
    dir_rows[10] = '{OP_UNUSED, 64'd0, 32'd0, 0, '0};                   // unknown op
    dir_rows[11] = '{pws_pkg::OP_TICK, pws_pkg::NEVER, 32'd0, 0, '0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].now, dir_rows[i].ack,
                dir_rows[i].typed, dir_rows[i].want);
    drain();

    // Extreme settings: burst cap and wraps, zero window, zero payload with zero rate.
    write_all(34'd1, 34'd131070, 34'd12500000000, 34'hFFFFFFF0, 34'd65530, 34'd1);
    cur_now = 64'd10;
    send_word(pws_pkg::OP_RESTART, cur_now, 32'd0);
    repeat (20) random_word();
    drain();
    write_all(34'd1460, 34'd0, 34'd1, 34'd0, 34'd0, 34'hFFFFFFFF);
    send_word(pws_pkg::OP_RESTART, cur_now, 32'd0);
    repeat (20) random_word();
    drain();
    write_all(34'd0, 34'd65535, 34'd0, 34'd5, 34'd65535, 34'd1000);
    write_reg(REG_UNUSED6, 34'($urandom));   // unknown register index
    write_reg(REG_UNUSED7, 34'($urandom));
    send_word(pws_pkg::OP_RESTART, cur_now, 32'd0);
    repeat (20) random_word();
    drain();

    // Random phases, each with fresh registers and an idle mode taken in turn from the four.
    for (int ph = 0; ph < 6; ph++) begin
      idle_mode = ph % 4;
      write_all(34'($urandom_range(1460, 1)), 34'($urandom_range(131070)),
                34'({$urandom_range(3), $urandom}), 34'($urandom),
                34'($urandom_range(65535)),
                34'($urandom_range(1) ? $urandom_range(5000000, 1) : $urandom));
      cur_now = {$urandom_range(3), $urandom};
      send_word(pws_pkg::OP_RESTART, cur_now, 32'd0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == 20) hold_req = 400;   // receiver hold-off, input backs up
        random_word();
      end
      drain();
    end
    idle_mode = 0;

    $display("ran %0d ticks (%0d bursts sent, %0d timeouts), %0d result words checked",
             n_ticks, n_sends, n_timeouts, n_words);
    $display("covered default and extreme registers plus six random phases with stalls");
    if (errors == 0)
      $display("paced_window_sender_unit_tb: PASS");
    else
      $display("paced_window_sender_unit_tb: FAIL");
    $finish;
  end

endmodule

@@ paced_window_sender_unit.f @@
hw/rtl/pws_pkg.sv
hw/rtl/pws_divider.sv
hw/rtl/pws_datapath.sv
hw/rtl/pws_control.sv
hw/rtl/paced_window_sender_unit.sv
dv/paced_window_sender_unit_tb.sv
